// File: hw/rtl/rtufa_pkg.sv
// Shared types, constants and codes for the RTU frame assembler.
package rtufa_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES = 8;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam int DATA_W      = 64;

  typedef logic [CNT_W-1:0] count_t;
  localparam count_t LAST_INDEX = count_t'(FRAME_BYTES - 1);

  // Input operation codes.
  typedef logic [2:0] op_t;
  localparam op_t OP_BYTE       = 3'd0;
  localparam op_t OP_LINE_ERROR = 3'd1;
  localparam op_t OP_TICK       = 3'd2;
  localparam op_t OP_IDLE_LINE  = 3'd3;
  localparam op_t OP_TX_DONE    = 3'd4;

  // Configuration register indexes.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_MODE          = 2'd0;
  localparam cfg_index_t CFG_HEADER_VALUE  = 2'd1;
  localparam cfg_index_t CFG_SILENCE_TICKS = 2'd2;

  // Register reset values.
  localparam logic [15:0] SILENCE_TICKS_RESET = 16'd305;

  // Operating modes.
  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_RTU   = 1'b1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic        mode;
    logic [7:0]  header_value;
    logic [15:0] silence_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic              frame_valid;
    logic [DATA_W-1:0] frame_data;
    logic              bus_idle;
  } res_t;

endpackage

// File: hw/rtl/rtu_frame_assembler_silence_timeout_top.sv
// RTU frame assembler: one item enters, the single-pass update runs, one result leaves.
// Path: the input register holds the accepted item, and one update pass through the frame and timer
// logic feeds the result register when that register is free or being emptied.
// Throughput: one item per cycle unless m_tready is low; both registers then stall together.
// Reset: byte count, timer and handshake state clear, the bus reads idle, mode is fixed
// frame, header 0 and silence window 305 ticks; the frame store is not cleared.
module rtu_frame_assembler_silence_timeout_top (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [2:0]  s_tuser,   // [2:0] operation
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] frame_data, [64] bus_idle, [71:65] zero
  output logic [0:0]  m_tuser,   // [0] frame_valid
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rtufa_pkg::cfg_t cfg;
  rtufa_pkg::res_t res;
  rtufa_pkg::res_t out_res;
  logic            in_valid;
  rtufa_pkg::op_t  in_op;
  logic [7:0]      in_byte;
  logic            advance;

  assign cfg_ready = 1'b1;

  rtufa_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held item moves on whenever the result register is free or being emptied.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  rtufa_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .op      (in_op),
    .rx_byte (in_byte),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.bus_idle, out_res.frame_data};
  assign m_tuser = out_res.frame_valid;

`ifndef NO_ASSERTIONS
  // A result without a frame carries no frame bytes.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[63:0] == 64'd0))
    else $error("frame data not zero on a result without a frame");

  // With both registers empty the block must take an item.
  assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !in_valid) |-> s_tready)
    else $error("input stalled while the block is empty");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result offered straight after reset");

  // A held item that cannot move keeps the input stalled.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("item accepted while the pipeline is blocked");
`endif

endmodule

// File: hw/rtl/rtufa_cfg.sv
// Configuration register bank of the RTU frame assembler.
module rtufa_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  rtufa_pkg::cfg_index_t wr_index,
  input  logic [15:0]           wr_data,
  output rtufa_pkg::cfg_t       cfg
);

  rtufa_pkg::cfg_t regs;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode          <= rtufa_pkg::MODE_FIXED;
      regs.header_value  <= 8'd0;
      regs.silence_ticks <= rtufa_pkg::SILENCE_TICKS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        rtufa_pkg::CFG_MODE:          regs.mode          <= wr_data[0];
        rtufa_pkg::CFG_HEADER_VALUE:  regs.header_value  <= wr_data[7:0];
        rtufa_pkg::CFG_SILENCE_TICKS: regs.silence_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hw/rtl/rtufa_core.sv
// Frame, byte count, silence timer and idle flag update for one item.
module rtufa_core (
  input  logic             clk,
  input  logic             rst,
  input  rtufa_pkg::cfg_t  cfg,
  input  logic             step,
  input  rtufa_pkg::op_t   op,
  input  logic [7:0]       rx_byte,
  output rtufa_pkg::res_t  res
);

  rtufa_pkg::count_t byte_count, byte_count_next;
  logic [7:0]        frame_store [rtufa_pkg::FRAME_BYTES];
  logic [7:0]        frame_bytes [rtufa_pkg::FRAME_BYTES];
  logic [15:0]       silence_remaining, silence_remaining_next;
  logic              timer_running, timer_running_next;
  logic              idle_flag, idle_flag_next;
  logic [15:0]       restart_value;
  logic              store_wr;
  logic              frame_done;

  // A zero window behaves as a window of one tick.
  assign restart_value = (cfg.silence_ticks == 16'd0) ? 16'd1 : cfg.silence_ticks;

  // The frame as it stands once the incoming byte is placed at the count.
  always_comb begin
    for (int k = 0; k < rtufa_pkg::FRAME_BYTES; k++) begin
      frame_bytes[k] = (rtufa_pkg::count_t'(k) == byte_count) ? rx_byte : frame_store[k];
    end
  end

  // Next state and the result of this item.
  always_comb begin
    byte_count_next        = byte_count;
    silence_remaining_next = silence_remaining;
    timer_running_next     = timer_running;
    idle_flag_next         = idle_flag;
    store_wr               = 1'b0;
    frame_done             = 1'b0;
    case (op)
      rtufa_pkg::OP_BYTE: begin
        store_wr = 1'b1;
        if (cfg.mode == rtufa_pkg::MODE_RTU) begin
          idle_flag_next         = 1'b0;
          silence_remaining_next = restart_value;
          timer_running_next     = 1'b1;
        end
        if (byte_count == rtufa_pkg::LAST_INDEX) begin
          byte_count_next = '0;
          frame_done = (cfg.mode == rtufa_pkg::MODE_RTU) ||
                       (frame_bytes[0] == cfg.header_value);
        end else begin
          byte_count_next = byte_count + rtufa_pkg::count_t'(1);
        end
      end
      rtufa_pkg::OP_LINE_ERROR: begin
        byte_count_next = '0;
      end
      rtufa_pkg::OP_TICK: begin
        if (timer_running) begin
          if (silence_remaining <= 16'd1) begin
            silence_remaining_next = 16'd0;
            timer_running_next     = 1'b0;
            idle_flag_next         = 1'b1;
            if (cfg.mode == rtufa_pkg::MODE_RTU) begin
              byte_count_next = '0;
            end
          end else begin
            silence_remaining_next = silence_remaining - 16'd1;
          end
        end
      end
      rtufa_pkg::OP_IDLE_LINE: begin
        if (cfg.mode == rtufa_pkg::MODE_RTU) begin
          silence_remaining_next = restart_value;
          timer_running_next     = 1'b1;
        end
      end
      rtufa_pkg::OP_TX_DONE: begin
        idle_flag_next         = 1'b0;
        silence_remaining_next = restart_value;
        timer_running_next     = 1'b1;
      end
      default: ;
    endcase
  end

  // Pack the delivered frame, first byte lowest; without a frame the data stays zero.
  always_comb begin
    res.frame_data = '0;
    if (frame_done) begin
      for (int k = 0; k < rtufa_pkg::FRAME_BYTES; k++) begin
        res.frame_data[8*k +: 8] = frame_bytes[k];
      end
    end
    res.frame_valid = frame_done;
    res.bus_idle    = idle_flag_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      silence_remaining <= 16'd0;
      timer_running     <= 1'b0;
      idle_flag         <= 1'b1;
    end else if (step) begin
      byte_count        <= byte_count_next;
      silence_remaining <= silence_remaining_next;
      timer_running     <= timer_running_next;
      idle_flag         <= idle_flag_next;
    end
  end

  // Frame bytes are payload and need no reset.
  always_ff @(posedge clk) begin
    if (step && store_wr) begin
      frame_store[byte_count] <= rx_byte;
    end
  end

endmodule
